@@ rtl/ppc_pkg.sv @@
package ppc_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int REG_BITS     = 12;
    localparam int LATCH_BITS   = 12;
    localparam int AMPS_BITS    = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int WINDOWS      = 6;

    localparam logic [CFG_IDX_BITS-1:0] REG_CHANGE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNPLUGGED_LEVEL  = 2'd2;

    localparam logic [REG_BITS-1:0] CHANGE_THRESHOLD_RESET = 12'd20;
    localparam logic [REG_BITS-1:0] WINDOW_TOLERANCE_RESET = 12'd40;
    localparam logic [REG_BITS-1:0] UNPLUGGED_LEVEL_RESET  = 12'd4076;

    typedef enum logic [2:0] {
        CLASS_UNPLUGGED = 3'd0,
        CLASS_TETHERED  = 3'd1,
        CLASS_RELEASE   = 3'd2,
        CLASS_20A       = 3'd3,
        CLASS_32A       = 3'd4,
        CLASS_63A       = 3'd5,
        CLASS_80A       = 3'd6,
        CLASS_ERROR     = 3'd7
    } port_class_t;

    // Windows in priority order.
    localparam logic [REG_BITS-1:0] WIN_LEVEL [WINDOWS] = '{
        12'd1868, 12'd3345, 12'd3861, 12'd2367, 12'd1403, 12'd804
    };
    localparam port_class_t WIN_CLASS [WINDOWS] = '{
        CLASS_TETHERED, CLASS_RELEASE, CLASS_20A, CLASS_32A, CLASS_63A, CLASS_80A
    };
    localparam logic [AMPS_BITS-1:0] WIN_AMPS [WINDOWS] = '{
        7'd0, 7'd0, 7'd20, 7'd32, 7'd63, 7'd80
    };

    typedef struct packed {
        logic [AMPS_BITS-1:0]  cable_amps;
        port_class_t           port_class;
        logic [LATCH_BITS-1:0] latched_value;
        logic                  changed;
    } result_t;

endpackage

@@ rtl/proximity_pilot_classifier_unit.sv @@
// Channel   Direction  Payload (lowest bit first)
// s_*       in         tdata: sample
// m_*       out        tdata: changed, latched_value, port_class, cable_amps
// cfg_*     in         write only: change_threshold, window_tolerance, unplugged_level
//
// Each transfer in yields one transfer out; the result is registered, via the skid register when the output stalls.
// A new sample is accepted in every cycle while the skid register is empty; the change compare and the window
// classification form one combinational pass into the result register.
// A skid register holds one result while the output stalls, so the input side stays open until it fills.
// Reset restores the register defaults and clears both stored samples.
module proximity_pilot_classifier_unit #(
    parameter int SAMPLE_BITS = ppc_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample, zero padded to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // changed, latched_value, port_class, cable_amps, one zero pad bit
    output logic [$bits(ppc_pkg::result_t):0]      m_tdata,
    input  logic                                   cfg_we,
    input  logic [ppc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [ppc_pkg::REG_BITS-1:0]           cfg_data
);

    localparam int VW = (SAMPLE_BITS > ppc_pkg::REG_BITS) ? SAMPLE_BITS : ppc_pkg::REG_BITS;
    localparam int CW = VW + 1;

    logic [ppc_pkg::REG_BITS-1:0] threshold_reg;
    logic [ppc_pkg::REG_BITS-1:0] tolerance_reg;
    logic [ppc_pkg::REG_BITS-1:0] unplugged_reg;
    logic [SAMPLE_BITS-1:0]       prev_reg;
    logic [SAMPLE_BITS-1:0]       held_reg;
    logic [SAMPLE_BITS-1:0]       held_next;
    logic [SAMPLE_BITS-1:0]       sample;
    logic                         accept;
    logic                         changed;
    logic [CW-1:0]                sample_ext;
    logic [CW-1:0]                prev_ext;
    logic [CW-1:0]                thr_ext;
    logic [CW-1:0]                v_ext;
    logic [CW-1:0]                tol_ext;
    logic [CW-1:0]                lvl_ext;
    logic [VW-1:0]                held_wide;
    logic                         found;
    ppc_pkg::result_t             result;
    ppc_pkg::result_t             out_reg;
    ppc_pkg::result_t             skid_reg;
    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    logic                         out_free;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        sample_ext = CW'(sample);
        prev_ext   = CW'(prev_reg);
        thr_ext    = CW'(threshold_reg);
        changed    = ((sample_ext + thr_ext) < prev_ext) || (sample_ext > (prev_ext + thr_ext));
        held_next  = changed ? sample : held_reg;
    end

    always_comb
    begin
        held_wide = VW'(held_next);
        v_ext     = CW'(held_next);
        tol_ext   = CW'(tolerance_reg);
        lvl_ext   = '0;
        found     = 1'b0;
        result.changed       = changed;
        result.latched_value = held_wide[ppc_pkg::LATCH_BITS-1:0];
        result.port_class    = ppc_pkg::CLASS_ERROR;
        result.cable_amps    = '0;
        if (v_ext > CW'(unplugged_reg))
        begin
            result.port_class = ppc_pkg::CLASS_UNPLUGGED;
        end
        else
        begin
            for (int i = 0; i < ppc_pkg::WINDOWS; i++)
            begin
                lvl_ext = CW'(ppc_pkg::WIN_LEVEL[i]);
                if (!found && ((v_ext + tol_ext) > lvl_ext) && (v_ext < (lvl_ext + tol_ext)))
                begin
                    found             = 1'b1;
                    result.port_class = ppc_pkg::WIN_CLASS[i];
                    result.cable_amps = ppc_pkg::WIN_AMPS[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ppc_pkg::CHANGE_THRESHOLD_RESET;
            tolerance_reg <= ppc_pkg::WINDOW_TOLERANCE_RESET;
            unplugged_reg <= ppc_pkg::UNPLUGGED_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppc_pkg::REG_CHANGE_THRESHOLD: threshold_reg <= cfg_data;
                ppc_pkg::REG_WINDOW_TOLERANCE: tolerance_reg <= cfg_data;
                ppc_pkg::REG_UNPLUGGED_LEVEL:  unplugged_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg <= sample;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_free && !skid_valid_reg) |=> out_valid_reg)
        else $error("accepted sample did not reach the output register");

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (prev_reg == $past(sample)))
        else $error("previous sample not updated on transfer");

    a_amps_class: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.cable_amps != '0)) |->
        (out_reg.port_class == ppc_pkg::CLASS_20A || out_reg.port_class == ppc_pkg::CLASS_32A ||
         out_reg.port_class == ppc_pkg::CLASS_63A || out_reg.port_class == ppc_pkg::CLASS_80A))
        else $error("cable rating reported for a class without one");

endmodule
